// ===== src/nnis_pkg.sv =====
package nnis_pkg;

  localparam int MAX_DIM_DEFAULT = 256;
  localparam int CHANNELS        = 3;
  localparam int BYTE_W          = 8;
  localparam int PIXEL_W         = CHANNELS * BYTE_W;
  localparam int CFG_IDX_W       = 4;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = CFG_IDX_W'(3);

endpackage

// ===== src/nnis_divider.sv =====
module nnis_divider #(
  parameter int W = 9
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     shreg;      // dividend bits shift out, quotient bits shift in
  logic [W-1:0]     divisor;
  logic [W-1:0]     partial;
  logic [CNT_W-1:0] count;
  logic [W:0]       trial;
  logic             fits;

  assign trial = {partial, shreg[W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      count   <= '0;
      shreg   <= W'(1);      // reset dims are equal: quotient one, remainder zero
      partial <= '0;
      divisor <= W'(1);
    end else if (start) begin
      busy    <= 1'b1;
      count   <= CNT_W'(W);
      shreg   <= num;
      partial <= '0;
      divisor <= den;
    end else if (busy) begin
      partial <= fits ? W'(trial - {1'b0, divisor}) : trial[W-1:0];
      shreg   <= {shreg[W-2:0], fits};
      count   <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quot = shreg;
  assign rem  = partial;

endmodule

// ===== src/nearest_neighbor_image_scaler.sv =====
// Nearest-neighbor image resizer for 3-byte pixels. A load transaction
// (operation = load) writes the next source pixel, in raster order, into an
// on-chip frame store of MAX_DIM*MAX_DIM pixels; the load cursor wraps after
// src_width*src_height pixels. An emit transaction returns the next
// destination pixel in raster order, taken from source column
// floor(x*src_width/dst_width) and row floor(y*src_height/dst_height),
// tracked exactly with step/remainder accumulators; frame_last marks the
// final pixel and the output cursor then wraps to the origin. Loads give no
// output. One transaction is taken per clock while in_stall is low; an emit
// result passes through the frame store read and then the output register.
// Writing any of the four dimension registers restarts both cursors and
// recomputes the per-pixel column and row steps on two bit-serial
// dividers, which hold in_stall high until both are done. Store entries
// that were never loaded read as undefined data. Out-of-range dimension
// writes are clamped to 1..MAX_DIM; writes to unknown indexes are ignored.
module nearest_neighbor_image_scaler #(
  parameter int  MAX_DIM = nnis_pkg::MAX_DIM_DEFAULT,
  localparam int DIM_W   = $clog2(MAX_DIM + 1),
  localparam int CW      = $clog2(MAX_DIM)
) (
  input  logic                           clk,
  input  logic                           rst,
  // input transactions
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           operation,
  input  logic [nnis_pkg::BYTE_W-1:0]    in_red,
  input  logic [nnis_pkg::BYTE_W-1:0]    in_green,
  input  logic [nnis_pkg::BYTE_W-1:0]    in_blue,
  // output transactions
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [nnis_pkg::BYTE_W-1:0]    out_red,
  output logic [nnis_pkg::BYTE_W-1:0]    out_green,
  output logic [nnis_pkg::BYTE_W-1:0]    out_blue,
  output logic [CW-1:0]                  dst_col,
  output logic [CW-1:0]                  dst_row,
  output logic                           frame_last,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nnis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]               cfg_data
);

  import nnis_pkg::*;

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW          = $clog2(STORE_DEPTH);

  // ---------------------------------------------------------------------------
  // Dimension registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] src_width, src_height, dst_width, dst_height;
  logic [DIM_W-1:0] cfg_clamped;
  logic             cfg_fire;
  logic             cfg_known;
  logic             restart;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_known = (cfg_index == CFG_SRC_WIDTH) || (cfg_index == CFG_SRC_HEIGHT) ||
                     (cfg_index == CFG_DST_WIDTH) || (cfg_index == CFG_DST_HEIGHT);
  assign restart   = cfg_fire && cfg_known;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = DIM_W'(1);
    end else if (cfg_data > DIM_W'(MAX_DIM)) begin
      cfg_clamped = DIM_W'(MAX_DIM);
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= DIM_W'(MAX_DIM);
      src_height <= DIM_W'(MAX_DIM);
      dst_width  <= DIM_W'(MAX_DIM);
      dst_height <= DIM_W'(MAX_DIM);
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_width  <= cfg_clamped;
        CFG_SRC_HEIGHT: src_height <= cfg_clamped;
        CFG_DST_WIDTH:  dst_width  <= cfg_clamped;
        CFG_DST_HEIGHT: dst_height <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // source pixel count, refreshed every cycle; settles during the divide stall
  logic [AW:0] total_pixels;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_pixels <= (AW+1)'(STORE_DEPTH);
    end else begin
      total_pixels <= (AW+1)'(src_width) * (AW+1)'(src_height);
    end
  end

  // ---------------------------------------------------------------------------
  // Step dividers: src/dst quotient and remainder per axis
  // ---------------------------------------------------------------------------
  logic             div_start;
  logic             col_busy, row_busy;
  logic [DIM_W-1:0] col_q, col_r, row_q, row_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= restart;
    end
  end

  nnis_divider #(.W(DIM_W)) u_col_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (src_width),
    .den   (dst_width),
    .busy  (col_busy),
    .quot  (col_q),
    .rem   (col_r)
  );

  nnis_divider #(.W(DIM_W)) u_row_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (src_height),
    .den   (dst_height),
    .busy  (row_busy),
    .quot  (row_q),
    .rem   (row_r)
  );

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic s1_valid;          // emit waiting on frame store read data
  logic s1_move;
  logic in_fire, load_fire, emit_fire;

  assign s1_move   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = div_start || col_busy || row_busy ||
                     (s1_valid && out_valid && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign load_fire = in_fire && (operation == OP_LOAD);
  assign emit_fire = in_fire && (operation == OP_EMIT);

  // ---------------------------------------------------------------------------
  // Cursors and accumulators
  // ---------------------------------------------------------------------------
  logic [AW-1:0]    load_cursor;
  logic [AW:0]      load_inc;
  logic [CW-1:0]    out_col, out_row;
  logic [CW-1:0]    src_col_acc, src_row_acc;
  logic [DIM_W-1:0] col_remainder, row_remainder;

  logic [DIM_W-1:0] col_inc, row_inc;
  logic             row_end, last;
  logic [DIM_W:0]   col_sum, row_sum;
  logic             col_carry, row_carry;
  logic [DIM_W-1:0] col_remainder_next, row_remainder_next;
  logic [CW-1:0]    src_col_acc_next, src_row_acc_next;

  assign load_inc = (AW+1)'(load_cursor) + (AW+1)'(1);

  assign col_inc = DIM_W'(out_col) + DIM_W'(1);
  assign row_inc = DIM_W'(out_row) + DIM_W'(1);
  assign row_end = (col_inc >= dst_width);
  assign last    = row_end && (row_inc >= dst_height);

  // remainder stays below the divisor, so one conditional subtract suffices
  assign col_sum   = (DIM_W+1)'(col_remainder) + (DIM_W+1)'(col_r);
  assign col_carry = (col_sum >= (DIM_W+1)'(dst_width));
  assign col_remainder_next = col_carry ? DIM_W'(col_sum - (DIM_W+1)'(dst_width))
                                        : DIM_W'(col_sum);
  assign src_col_acc_next   = src_col_acc + CW'(col_q) + CW'(col_carry);

  assign row_sum   = (DIM_W+1)'(row_remainder) + (DIM_W+1)'(row_r);
  assign row_carry = (row_sum >= (DIM_W+1)'(dst_height));
  assign row_remainder_next = row_carry ? DIM_W'(row_sum - (DIM_W+1)'(dst_height))
                                        : DIM_W'(row_sum);
  assign src_row_acc_next   = src_row_acc + CW'(row_q) + CW'(row_carry);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      load_cursor   <= '0;
      out_col       <= '0;
      out_row       <= '0;
      src_col_acc   <= '0;
      col_remainder <= '0;
      src_row_acc   <= '0;
      row_remainder <= '0;
    end else begin
      if (load_fire) begin
        load_cursor <= (load_inc >= total_pixels) ? '0 : load_inc[AW-1:0];
      end
      if (emit_fire) begin
        if (!row_end) begin
          out_col       <= col_inc[CW-1:0];
          src_col_acc   <= src_col_acc_next;
          col_remainder <= col_remainder_next;
        end else begin
          out_col       <= '0;
          src_col_acc   <= '0;
          col_remainder <= '0;
          if (last) begin
            out_row       <= '0;
            src_row_acc   <= '0;
            row_remainder <= '0;
          end else begin
            out_row       <= row_inc[CW-1:0];
            src_row_acc   <= src_row_acc_next;
            row_remainder <= row_remainder_next;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Frame store: one write port (loads), one registered read port (emits)
  // ---------------------------------------------------------------------------
  logic [PIXEL_W-1:0] frame_store [STORE_DEPTH];
  logic [PIXEL_W-1:0] rd_data;
  logic [AW-1:0]      rd_addr;

  assign rd_addr = AW'(src_row_acc) * AW'(src_width) + AW'(src_col_acc);

  always_ff @(posedge clk) begin
    if (load_fire) begin
      frame_store[load_cursor] <= {in_blue, in_green, in_red};
    end
    if (emit_fire) begin
      rd_data <= frame_store[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Read stage and output register
  // ---------------------------------------------------------------------------
  logic [CW-1:0] s1_col, s1_row;
  logic          s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (emit_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      s1_col  <= out_col;
      s1_row  <= out_row;
      s1_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_red    <= rd_data[BYTE_W-1:0];
      out_green  <= rd_data[2*BYTE_W-1:BYTE_W];
      out_blue   <= rd_data[3*BYTE_W-1:2*BYTE_W];
      dst_col    <= s1_col;
      dst_row    <= s1_row;
      frame_last <= s1_last;
    end
  end

endmodule

// ===== src/nnis_checker.sv =====
module nnis_checker #(
  parameter int  MAX_DIM = nnis_pkg::MAX_DIM_DEFAULT,
  localparam int CW      = $clog2(MAX_DIM)
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           operation,
  input logic [nnis_pkg::BYTE_W-1:0]    in_red,
  input logic [nnis_pkg::BYTE_W-1:0]    in_green,
  input logic [nnis_pkg::BYTE_W-1:0]    in_blue,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [nnis_pkg::BYTE_W-1:0]    out_red,
  input logic [nnis_pkg::BYTE_W-1:0]    out_green,
  input logic [nnis_pkg::BYTE_W-1:0]    out_blue,
  input logic [CW-1:0]                  dst_col,
  input logic [CW-1:0]                  dst_row,
  input logic                           frame_last,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [nnis_pkg::CFG_IDX_W-1:0] cfg_index
);

  import nnis_pkg::*;

  logic cfg_known_write;

  assign cfg_known_write = cfg_valid && cfg_ready &&
                           ((cfg_index == CFG_SRC_WIDTH) || (cfg_index == CFG_SRC_HEIGHT) ||
                            (cfg_index == CFG_DST_WIDTH) || (cfg_index == CFG_DST_HEIGHT));

  // stalled input transaction waits unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid &&
      $stable(operation) && $stable(in_red) && $stable(in_green) && $stable(in_blue))
    else $error("stalled input transaction changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable(out_red) && $stable(out_green) && $stable(out_blue) &&
      $stable(dst_col) && $stable(dst_row) && $stable(frame_last))
    else $error("stalled output transaction changed");

  // an accepted emit shows a result after the frame store read stage
  a_emit_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (operation == OP_EMIT) |=> ##1 out_valid)
    else $error("emit transaction produced no result");

  // a dimension write recomputes the steps before new input is taken
  a_cfg_interlock: assert property (@(posedge clk) disable iff (rst)
    cfg_known_write |=> in_stall)
    else $error("input taken while step dividers restart");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind nearest_neighbor_image_scaler nnis_checker #(.MAX_DIM(MAX_DIM)) u_nnis_checker (.*);
